// ===== sv/bic_pkg.sv =====
// Shared types, constants and register map of the backlight inactivity controller.
`default_nettype none
package bic_pkg;

  localparam int DUTY_BITS_DEFAULT    = 10;
  localparam int ELAPSED_BITS_DEFAULT = 32;
  localparam int APB_ADDR_BITS        = 5;
  localparam int REG_IDX_BITS         = 3;

  localparam logic [6:0] MAX_PERCENT = 7'd100;
  localparam logic [4:0] MAX_HOUR    = 5'd23;

  localparam logic [6:0]  ACTIVE_LEVEL_RST = 7'd100;
  localparam logic [6:0]  DIM_LEVEL_RST    = 7'd30;
  localparam logic [31:0] DIM_TIMEOUT_RST  = 32'd30000;
  localparam logic [31:0] OFF_TIMEOUT_RST  = 32'd120000;
  localparam logic        NIGHT_EN_RST     = 1'b0;
  localparam logic [4:0]  NIGHT_START_RST  = 5'd22;
  localparam logic [4:0]  NIGHT_END_RST    = 5'd7;
  localparam logic [6:0]  SS_LEVEL_RST     = 7'd0;

  typedef enum logic [REG_IDX_BITS-1:0] {
    RegActiveLevel = 3'd0,
    RegDimLevel    = 3'd1,
    RegDimTimeout  = 3'd2,
    RegOffTimeout  = 3'd3,
    RegNightEnable = 3'd4,
    RegNightStart  = 3'd5,
    RegNightEnd    = 3'd6,
    RegSsLevel     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ReqTick     = 2'd0,
    ReqActivity = 2'd1,
    ReqEvaluate = 2'd2,
    ReqForce    = 2'd3
  } req_e;

  typedef struct packed {
    logic [6:0]  active_level;
    logic [6:0]  dim_level;
    logic [31:0] dim_timeout;
    logic [31:0] off_timeout;
    logic        night_enable;
    logic [4:0]  night_start;
    logic [4:0]  night_end;
    logic [6:0]  screensaver_level;
  } cfg_t;

  typedef struct packed {
    req_e       req_type;
    logic [4:0] hour_now;
    logic       clock_valid;
    logic [6:0] force_level;
  } item_t;

  typedef struct packed {
    logic       backlight_write;
    logic [6:0] level_now;
    logic       screensaver_on;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/bic_req_if.sv =====
// Request channel carrying one controller input transaction.
`default_nettype none
interface bic_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [4:0] hour_now;
  logic       clock_valid;
  logic [6:0] force_level;

  modport source (output valid, output req_type, output hour_now, output clock_valid,
                  output force_level, input ready);
  modport sink (input valid, input req_type, input hour_now, input clock_valid,
                input force_level, output ready);
endinterface
`default_nettype wire

// ===== sv/bic_rsp_if.sv =====
// Response channel carrying one controller result transaction.
`default_nettype none
interface bic_rsp_if #(
  parameter int DUTY_BITS = bic_pkg::DUTY_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic                 backlight_write;
  logic [DUTY_BITS-1:0] duty_value;
  logic [6:0]           level_now;
  logic                 screensaver_on;

  modport source (output valid, output backlight_write, output duty_value,
                  output level_now, output screensaver_on, input ready);
  modport sink (input valid, input backlight_write, input duty_value,
                input level_now, input screensaver_on, output ready);
endinterface
`default_nettype wire

// ===== sv/bic_cfg_regs.sv =====
// APB configuration register file of the backlight inactivity controller.
`default_nettype none
module bic_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bic_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output bic_pkg::cfg_t                     cfg_o
);
  import bic_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level      <= ACTIVE_LEVEL_RST;
      cfg_q.dim_level         <= DIM_LEVEL_RST;
      cfg_q.dim_timeout       <= DIM_TIMEOUT_RST;
      cfg_q.off_timeout       <= OFF_TIMEOUT_RST;
      cfg_q.night_enable      <= NIGHT_EN_RST;
      cfg_q.night_start       <= NIGHT_START_RST;
      cfg_q.night_end         <= NIGHT_END_RST;
      cfg_q.screensaver_level <= SS_LEVEL_RST;
    end else if (wr_en) begin
      case (idx)
        RegActiveLevel: cfg_q.active_level      <= pwdata[6:0];
        RegDimLevel:    cfg_q.dim_level         <= pwdata[6:0];
        RegDimTimeout:  cfg_q.dim_timeout       <= pwdata;
        RegOffTimeout:  cfg_q.off_timeout       <= pwdata;
        RegNightEnable: cfg_q.night_enable      <= pwdata[0];
        RegNightStart:  cfg_q.night_start       <= pwdata[4:0];
        RegNightEnd:    cfg_q.night_end         <= pwdata[4:0];
        RegSsLevel:     cfg_q.screensaver_level <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegActiveLevel: prdata = {25'd0, cfg_q.active_level};
      RegDimLevel:    prdata = {25'd0, cfg_q.dim_level};
      RegDimTimeout:  prdata = cfg_q.dim_timeout;
      RegOffTimeout:  prdata = cfg_q.off_timeout;
      RegNightEnable: prdata = {31'd0, cfg_q.night_enable};
      RegNightStart:  prdata = {27'd0, cfg_q.night_start};
      RegNightEnd:    prdata = {27'd0, cfg_q.night_end};
      RegSsLevel:     prdata = {25'd0, cfg_q.screensaver_level};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/bic_ctrl.sv =====
// Inactivity state and level decision for one controller transaction.
`default_nettype none
module bic_ctrl #(
  parameter int ELAPSED_BITS = bic_pkg::ELAPSED_BITS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bic_pkg::cfg_t  cfg_i,
  input  bic_pkg::item_t item_i,
  input  logic           advance_i,
  output bic_pkg::res_t  res_o
);
  import bic_pkg::*;

  localparam int CmpBits = (ELAPSED_BITS > 32) ? ELAPSED_BITS : 32;

  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
  logic                    seen_q, seen_d;
  logic [6:0]              level_q, level_d;
  logic                    valid_q, valid_d;

  logic [6:0]         act_lvl, dim_lvl, ss_lvl, frc_lvl, tgt_lvl, new_lvl;
  logic [4:0]         start_h, end_h, hour_h;
  logic [CmpBits-1:0] elapsed_x, dim_x, off_x;
  logic               in_dim, night, off_cond, do_apply, wr;

  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    return (v > MAX_PERCENT) ? MAX_PERCENT : v;
  endfunction

  function automatic logic [4:0] clamp_hour(input logic [4:0] v);
    return (v > MAX_HOUR) ? MAX_HOUR : v;
  endfunction

  assign act_lvl = clamp_pct(cfg_i.active_level);
  assign dim_lvl = clamp_pct(cfg_i.dim_level);
  assign ss_lvl  = clamp_pct(cfg_i.screensaver_level);
  assign frc_lvl = clamp_pct(item_i.force_level);
  assign start_h = clamp_hour(cfg_i.night_start);
  assign end_h   = clamp_hour(cfg_i.night_end);
  assign hour_h  = clamp_hour(item_i.hour_now);

  always_comb begin
    elapsed_d = elapsed_q;
    seen_d    = seen_q;
    case (item_i.req_type)
      ReqTick: begin
        if (elapsed_q != {ELAPSED_BITS{1'b1}}) elapsed_d = elapsed_q + ELAPSED_BITS'(1);
      end
      ReqActivity: begin
        elapsed_d = '0;
        seen_d    = 1'b1;
      end
      default: ;
    endcase
  end

  assign elapsed_x = CmpBits'(elapsed_d);
  assign dim_x     = CmpBits'(cfg_i.dim_timeout);
  assign off_x     = CmpBits'(cfg_i.off_timeout);
  assign in_dim    = (cfg_i.dim_timeout != 32'd0) && (elapsed_x < dim_x);

  always_comb begin
    if (!cfg_i.night_enable || !item_i.clock_valid || start_h == end_h) begin
      night = 1'b0;
    end else if (start_h < end_h) begin
      night = (hour_h >= start_h) && (hour_h < end_h);
    end else begin
      night = (hour_h >= start_h) || (hour_h < end_h);
    end
  end

  assign off_cond = seen_d && !in_dim &&
                    (night || ((cfg_i.off_timeout != 32'd0) && (elapsed_x >= off_x)));

  always_comb begin
    if (!seen_d || in_dim) begin
      tgt_lvl = act_lvl;
    end else if (off_cond) begin
      tgt_lvl = ss_lvl;
    end else begin
      tgt_lvl = dim_lvl;
    end
  end

  always_comb begin
    do_apply = 1'b1;
    case (item_i.req_type)
      ReqTick:     begin do_apply = 1'b0; new_lvl = level_q; end
      ReqActivity: new_lvl = act_lvl;
      ReqEvaluate: new_lvl = tgt_lvl;
      ReqForce:    new_lvl = frc_lvl;
      default:     begin do_apply = 1'b0; new_lvl = level_q; end
    endcase
  end

  assign wr      = do_apply && (!valid_q || level_q != new_lvl);
  assign level_d = wr ? new_lvl : level_q;
  assign valid_d = valid_q || do_apply;

  assign res_o.backlight_write = wr;
  assign res_o.level_now       = level_d;
  assign res_o.screensaver_on  = (ss_lvl != 7'd0) && off_cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      seen_q    <= 1'b0;
      level_q   <= 7'd0;
      valid_q   <= 1'b0;
    end else if (advance_i) begin
      elapsed_q <= elapsed_d;
      seen_q    <= seen_d;
      level_q   <= level_d;
      valid_q   <= valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bic_duty_scale.sv =====
// Percent to PWM duty scaling by a constant reciprocal product.
`default_nettype none
module bic_duty_scale #(
  parameter int DUTY_BITS = bic_pkg::DUTY_BITS_DEFAULT
) (
  input  logic [6:0]           level_i,
  output logic [DUTY_BITS-1:0] duty_o
);
  import bic_pkg::*;

  localparam int ShiftBits = DUTY_BITS + 14;
  localparam int ProdBits  = ShiftBits + DUTY_BITS;
  localparam logic [63:0] Pct      = 64'(MAX_PERCENT);
  localparam logic [63:0] Recip    = ((64'd1 << ShiftBits) + Pct - 64'd1) / Pct;
  localparam logic [63:0] DutyFull = (64'd1 << DUTY_BITS) - 64'd1;
  localparam logic [63:0] Scale    = DutyFull * Recip;

  logic [ProdBits-1:0] prod;

  assign prod   = ProdBits'(Scale) * ProdBits'(level_i);
  assign duty_o = prod[ShiftBits +: DUTY_BITS];

endmodule
`default_nettype wire

// ===== sv/backlight_inactivity_controller_unit.sv =====
// Top level of the backlight inactivity controller.
// Takes one request transaction per clock (tick, activity, evaluate or force) while
// req ready is high, and returns exactly one result transaction for each, in order.
// A request is held in an input register, then the level decision, state update and
// duty scaling run in a single combinational pass into the result register, from
// which the sink takes it; the sustained rate is one transaction per cycle while the
// sink does not stall; that pass (timeout compares, level select and one constant
// multiply) sets the clock. The result register holds while the sink stalls and
// the input register keeps accepting, so back-pressure reaches the request side
// only when both are full.
// Write the APB registers only while no transaction is in flight.
`default_nettype none
module backlight_inactivity_controller_unit #(
  parameter int DUTY_BITS    = bic_pkg::DUTY_BITS_DEFAULT,
  parameter int ELAPSED_BITS = bic_pkg::ELAPSED_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bic_req_if.sink                           req_i,
  bic_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bic_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bic_pkg::*;

  cfg_t                 cfg;
  item_t                item_q;
  res_t                 res_d, res_q;
  logic [DUTY_BITS-1:0] duty_d, duty_q;
  logic                 in_valid_q, out_valid_q;
  logic                 advance, take;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign take        = req_i.valid && req_i.ready;

  bic_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bic_ctrl #(.ELAPSED_BITS(ELAPSED_BITS)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .advance_i (advance),
    .res_o     (res_d)
  );

  bic_duty_scale #(.DUTY_BITS(DUTY_BITS)) u_duty (
    .level_i (res_d.level_now),
    .duty_o  (duty_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) in_valid_q <= req_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.req_type    <= req_e'(req_i.req_type);
      item_q.hour_now    <= req_i.hour_now;
      item_q.clock_valid <= req_i.clock_valid;
      item_q.force_level <= req_i.force_level;
    end
    if (advance) begin
      res_q  <= res_d;
      duty_q <= duty_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.backlight_write = res_q.backlight_write;
  assign rsp_o.duty_value      = duty_q;
  assign rsp_o.level_now       = res_q.level_now;
  assign rsp_o.screensaver_on  = res_q.screensaver_on;

endmodule
`default_nettype wire

// ===== bench/backlight_inactivity_controller_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the backlight controller: directed and random traffic against a predictor.
module backlight_inactivity_controller_unit_tb;
  import bic_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 90;
  localparam int DUTY_FULL      = (1 << DUTY_BITS_DEFAULT) - 1;

  typedef struct packed {
    logic                         wr;
    logic [DUTY_BITS_DEFAULT-1:0] duty;
    logic [6:0]                   lvl;
    logic                         ss;
  } bl_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bic_req_if req_if ();
  bic_rsp_if rsp_if ();

  backlight_inactivity_controller_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        shadow_cfg;
  logic [31:0] idle_ticks;
  logic        seen_activity;
  logic [6:0]  shown_level;
  logic        shown_valid;

  bl_result_t awaited_backlight[$];
  int         mismatch_count;
  int         idle_cycles = 0;
  int         phase_items;
  bit         no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [6:0] pct(logic [6:0] v);
    return (v > MAX_PERCENT) ? MAX_PERCENT : v;
  endfunction

  function automatic logic [4:0] hr(logic [4:0] v);
    return (v > MAX_HOUR) ? MAX_HOUR : v;
  endfunction

  function automatic logic dim_hold();
    return shadow_cfg.dim_timeout != 0 && idle_ticks < shadow_cfg.dim_timeout;
  endfunction

  function automatic logic night_window(logic [4:0] hour, logic valid);
    logic [4:0] s;
    logic [4:0] e;
    logic [4:0] h;
    s = hr(shadow_cfg.night_start);
    e = hr(shadow_cfg.night_end);
    h = hr(hour);
    if (!shadow_cfg.night_enable || !valid || s == e) return 1'b0;
    if (s < e) return h >= s && h < e;
    return h >= s || h < e;
  endfunction

  function automatic logic off_rule(logic [4:0] hour, logic valid);
    if (!seen_activity || dim_hold()) return 1'b0;
    if (night_window(hour, valid)) return 1'b1;
    return shadow_cfg.off_timeout != 0 && idle_ticks >= shadow_cfg.off_timeout;
  endfunction

  function automatic logic [6:0] choose_level(logic [4:0] hour, logic valid);
    if (!seen_activity || dim_hold()) return pct(shadow_cfg.active_level);
    if (off_rule(hour, valid)) return pct(shadow_cfg.screensaver_level);
    return pct(shadow_cfg.dim_level);
  endfunction

  function automatic logic commit_level(logic [6:0] lvl);
    if (shown_valid && shown_level == lvl) return 1'b0;
    shown_level = lvl;
    shown_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic bl_result_t predict_backlight(item_t it);
    bl_result_t r;
    r = '0;
    case (it.req_type)
      ReqTick: begin
        if (idle_ticks != '1) idle_ticks = idle_ticks + 1;
      end
      ReqActivity: begin
        idle_ticks = '0;
        seen_activity = 1'b1;
        r.wr = commit_level(pct(shadow_cfg.active_level));
      end
      ReqEvaluate: r.wr = commit_level(choose_level(it.hour_now, it.clock_valid));
      default: r.wr = commit_level(pct(it.force_level));
    endcase
    r.ss = pct(shadow_cfg.screensaver_level) != 0 && off_rule(it.hour_now, it.clock_valid);
    r.lvl = shown_level;
    r.duty = DUTY_BITS_DEFAULT'((DUTY_FULL * int'(shown_level)) / 100);
    return r;
  endfunction

  function automatic logic [4:0] rand_hour();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [6:0] rand_level();
    case ($urandom_range(0, 4))
      0: return 7'd0;
      1: return MAX_PERCENT;
      2: return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [31:0] rand_timeout();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic send_item(req_e kind, logic [4:0] hour, logic valid, logic [6:0] force_pct);
    int    gap;
    item_t it;
    it.req_type = kind;
    it.hour_now = hour;
    it.clock_valid = valid;
    it.force_level = force_pct;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.hour_now    <= hour;
    req_if.clock_valid <= valid;
    req_if.force_level <= force_pct;
    do @(posedge clk_i); while (!req_if.ready);
    awaited_backlight.push_back(predict_backlight(it));
    phase_items++;
  endtask

  task automatic flush_requests();
    req_if.valid <= 1'b0;
    while (awaited_backlight.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegActiveLevel: shadow_cfg.active_level = value[6:0];
      RegDimLevel:    shadow_cfg.dim_level = value[6:0];
      RegDimTimeout:  shadow_cfg.dim_timeout = value;
      RegOffTimeout:  shadow_cfg.off_timeout = value;
      RegNightEnable: shadow_cfg.night_enable = value[0];
      RegNightStart:  shadow_cfg.night_start = value[4:0];
      RegNightEnd:    shadow_cfg.night_end = value[4:0];
      default:        shadow_cfg.screensaver_level = value[6:0];
    endcase
  endtask

  task automatic program_config(cfg_t c);
    write_reg(RegActiveLevel, 32'(c.active_level));
    write_reg(RegDimLevel, 32'(c.dim_level));
    write_reg(RegDimTimeout, c.dim_timeout);
    write_reg(RegOffTimeout, c.off_timeout);
    write_reg(RegNightEnable, 32'(c.night_enable));
    write_reg(RegNightStart, 32'(c.night_start));
    write_reg(RegNightEnd, 32'(c.night_end));
    write_reg(RegSsLevel, 32'(c.screensaver_level));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_first_apply();
    send_item(ReqTick, 5'd0, 1'b0, 7'd0);
    send_item(ReqForce, 5'd0, 1'b0, 7'd0);
    send_item(ReqForce, 5'd31, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd0, 1'b0, 7'd0);
    send_item(ReqForce, 5'd0, 1'b0, 7'd127);
    send_item(ReqForce, 5'd0, 1'b0, 7'd101);
    send_item(ReqForce, 5'd0, 1'b0, 7'd50);
    send_item(ReqActivity, 5'd0, 1'b0, 7'd0);
    flush_requests();
  endtask

  task automatic test_timeouts();
    cfg_t c;
    c = '0;
    c.active_level = 7'd100;
    c.dim_level = 7'd30;
    c.dim_timeout = 32'd2;
    c.off_timeout = 32'd4;
    c.night_start = 5'd22;
    c.night_end = 5'd7;
    c.screensaver_level = 7'd40;
    program_config(c);
    send_item(ReqActivity, 5'd12, 1'b1, 7'd0);
    send_item(ReqTick, 5'd12, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd12, 1'b1, 7'd0);
    send_item(ReqTick, 5'd12, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd12, 1'b1, 7'd0);
    send_item(ReqTick, 5'd12, 1'b1, 7'd0);
    send_item(ReqTick, 5'd12, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd12, 1'b1, 7'd0);
    send_item(ReqTick, 5'd12, 1'b1, 7'd0);
    flush_requests();
  endtask

  task automatic test_night_window();
    cfg_t c;
    c = '0;
    c.active_level = 7'd80;
    c.dim_level = 7'd20;
    c.night_enable = 1'b1;
    c.night_start = 5'd31;
    c.night_end = 5'd2;
    c.screensaver_level = 7'd60;
    program_config(c);
    send_item(ReqActivity, 5'd0, 1'b0, 7'd0);
    send_item(ReqEvaluate, 5'd23, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd31, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd1, 1'b0, 7'd0);
    send_item(ReqEvaluate, 5'd5, 1'b1, 7'd0);
    send_item(ReqEvaluate, 5'd0, 1'b1, 7'd0);
    flush_requests();
  endtask

  task automatic test_random_traffic();
    cfg_t        c;
    logic [31:0] longest;
    int          reach;
    int          roll;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      c = '0;
      if (phase == 1) begin
        c = '1;
      end else if (phase > 1) begin
        c.active_level = rand_level();
        c.dim_level = rand_level();
        c.screensaver_level = rand_level();
        c.dim_timeout = rand_timeout();
        c.off_timeout = rand_timeout();
        c.night_enable = ($urandom_range(0, 3) != 0);
        c.night_start = 5'($urandom);
        c.night_end = 5'($urandom);
      end
      program_config(c);
      no_idle = (phase % 4 == 2);
      longest = (c.dim_timeout > c.off_timeout) ? c.dim_timeout : c.off_timeout;
      reach = (longest > 40) ? 40 : int'(longest);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_item(ReqActivity, rand_hour(), 1'($urandom), 7'($urandom));
          repeat ($urandom_range(1, 2 * reach + 4)) begin
            roll = $urandom_range(0, 19);
            if (roll < 11) begin
              send_item(ReqTick, 5'($urandom), 1'($urandom), 7'($urandom));
            end else if (roll < 19) begin
              send_item(ReqEvaluate, rand_hour(), ($urandom_range(0, 3) != 0), 7'($urandom));
            end else begin
              send_item(ReqForce, 5'($urandom), 1'($urandom), 7'($urandom));
            end
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(req_e'($urandom_range(0, 3)), 5'($urandom), 1'($urandom), 7'($urandom));
          end
        end
      end
      flush_requests();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= 2'd0;
    req_if.hour_now    <= 5'd0;
    req_if.clock_valid <= 1'b0;
    req_if.force_level <= 7'd0;
    rsp_if.ready       <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    mismatch_count = 0;
    no_idle = 1'b0;
    shadow_cfg.active_level = ACTIVE_LEVEL_RST;
    shadow_cfg.dim_level = DIM_LEVEL_RST;
    shadow_cfg.dim_timeout = DIM_TIMEOUT_RST;
    shadow_cfg.off_timeout = OFF_TIMEOUT_RST;
    shadow_cfg.night_enable = NIGHT_EN_RST;
    shadow_cfg.night_start = NIGHT_START_RST;
    shadow_cfg.night_end = NIGHT_END_RST;
    shadow_cfg.screensaver_level = SS_LEVEL_RST;
    idle_ticks = '0;
    seen_activity = 1'b0;
    shown_level = '0;
    shown_valid = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_apply();
    test_timeouts();
    test_night_window();
    test_random_traffic();
    flush_requests();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("backlight_inactivity_controller_unit_tb: clean");
    end else begin
      $display("backlight_inactivity_controller_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  always @(posedge clk_i) begin
    bl_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_backlight.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual level_now %0d", $time,
                 rsp_if.level_now);
        mismatch_count++;
      end else begin
        want = awaited_backlight.pop_front();
        if (rsp_if.backlight_write !== want.wr) begin
          $display("%0t: backlight_write expected %0b actual %0b", $time, want.wr,
                   rsp_if.backlight_write);
          mismatch_count++;
        end
        if (rsp_if.duty_value !== want.duty) begin
          $display("%0t: duty_value expected %0d actual %0d", $time, want.duty,
                   rsp_if.duty_value);
          mismatch_count++;
        end
        if (rsp_if.level_now !== want.lvl) begin
          $display("%0t: level_now expected %0d actual %0d", $time, want.lvl,
                   rsp_if.level_now);
          mismatch_count++;
        end
        if (rsp_if.screensaver_on !== want.ss) begin
          $display("%0t: screensaver_on expected %0b actual %0b", $time, want.ss,
                   rsp_if.screensaver_on);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("backlight_inactivity_controller_unit_tb: errors");
      $finish;
    end
  end

endmodule

// ===== backlight_inactivity_controller_unit.f =====
sv/bic_pkg.sv
sv/bic_req_if.sv
sv/bic_rsp_if.sv
sv/bic_cfg_regs.sv
sv/bic_ctrl.sv
sv/bic_duty_scale.sv
sv/backlight_inactivity_controller_unit.sv
bench/backlight_inactivity_controller_unit_tb.sv
